// File: rtl/greedy_load_balanced_assignment_core_assert.svh
// ----------------------------------------------------------------------------
// greedy load-balanced assignment: assertion macros
// Concurrent checks with a disable-on-reset guard, one per line of use.
// ----------------------------------------------------------------------------
`ifndef GREEDY_LOAD_BALANCED_ASSIGNMENT_CORE_ASSERT_SVH
`define GREEDY_LOAD_BALANCED_ASSIGNMENT_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define GLBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define GLBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/glba_pkg.sv
// ----------------------------------------------------------------------------
// glba_pkg
// Shared constants, codes, width helpers and control structs for the
// greedy load-balanced assignment core.
// ----------------------------------------------------------------------------
package glba_pkg;

  // default sizes
  localparam int MAX_ROBOTS_DEF = 16;
  localparam int MAX_GOALS_DEF  = 32;
  localparam int DIST_BITS_DEF  = 16;

  // fixed field widths
  localparam int ROBOT_W    = 4;
  localparam int GOAL_W     = 5;
  localparam int NROB_W     = 5;
  localparam int NGOAL_W    = 6;
  localparam int LOAD_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROBOTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_GOALS  = 1'b1;

  // bits needed to index a store of the given depth
  function automatic int idx_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // bits needed to hold a count from zero up to maxv
  function automatic int cnt_bits(input int maxv);
    return $clog2(maxv + 1);
  endfunction

  // matrix entry: a finite distance or the unreachable code rows*cols+1
  function automatic int entry_bits(input int mr, input int mg, input int db);
    int sent;
    sent = $clog2(mr * mg + 2);
    return (db > sent) ? db : sent;
  endfunction

  // sequencer to pick unit
  typedef struct packed {
    logic cand;   // candidate issued this cycle (goal still free)
    logic clear;  // forget the best pick of the previous step
  } pick_ctl_t;

  // pick unit to sequencer
  typedef struct packed {
    logic found;  // a best pick is held
    logic busy;   // candidates still in flight
  } pick_stat_t;

endpackage

// File: rtl/glba_ifs.sv
// ----------------------------------------------------------------------------
// glba channel interfaces
// Valid/ready channels for command items and assignment result items.
// ----------------------------------------------------------------------------
interface glba_cmd_if
  import glba_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [ROBOT_W-1:0]   robot_index;
  logic [GOAL_W-1:0]    goal_index;
  logic [DIST_BITS-1:0] distance;
  logic                 reachable;

  modport source (
    output valid, op, robot_index, goal_index, distance, reachable,
    input  ready
  );
  modport sink (
    input  valid, op, robot_index, goal_index, distance, reachable,
    output ready
  );
endinterface

interface glba_res_if
  import glba_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ROBOT_W-1:0] robot_out;
  logic [GOAL_W-1:0]  goal_out;
  logic               last;

  modport source (
    output valid, robot_out, goal_out, last,
    input  ready
  );
  modport sink (
    input  valid, robot_out, goal_out, last,
    output ready
  );
endinterface

// File: rtl/greedy_load_balanced_assignment_core.sv
// ----------------------------------------------------------------------------
// greedy_load_balanced_assignment_core
// Greedy load-balanced robot-to-goal assignment over a stored distance matrix.
// ----------------------------------------------------------------------------
// A write item stores one matrix entry; command items are accepted only while no
// run is in progress. A run item starts one greedy step per goal in use: each
// step sweeps every (goal, robot) pair through the single read port of the
// matrix memory, one pair a cycle, then waits while the cost pipeline drains
// and ends with an update that issues the result; the update waits while the
// result output is held back. The last result of a run carries last; loads,
// goal marks and the largest finite distance then return to zero while the
// matrix is kept. A run with no robots or no goals gives no result and only
// clears that state.
// ----------------------------------------------------------------------------
`include "greedy_load_balanced_assignment_core_assert.svh"

module greedy_load_balanced_assignment_core
  import glba_pkg::*;
#(
  parameter int MAX_ROBOTS = MAX_ROBOTS_DEF,
  parameter int MAX_GOALS  = MAX_GOALS_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  glba_cmd_if.sink              cmd,
  glba_res_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RIW    = idx_bits(MAX_ROBOTS);
  localparam int GIW    = idx_bits(MAX_GOALS);
  localparam int RCW    = cnt_bits(MAX_ROBOTS);
  localparam int GCW    = cnt_bits(MAX_GOALS);
  localparam int DEPTH  = MAX_ROBOTS * MAX_GOALS;
  localparam int AW     = idx_bits(DEPTH);
  localparam int EW     = entry_bits(MAX_ROBOTS, MAX_GOALS, DIST_BITS);
  localparam int COEF_W = DIST_BITS + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]           state;
  logic [NROB_W-1:0]    num_robots;
  logic [NGOAL_W-1:0]   num_goals;
  logic [DIST_BITS-1:0] largest;
  logic [MAX_GOALS-1:0] taken;
  logic [RIW-1:0]       r_cnt;
  logic [GIW-1:0]       g_cnt;
  logic [GIW-1:0]       step_cnt;

  logic [RCW-1:0]       n_use;
  logic [GCW-1:0]       m_use;
  logic                 cmd_fire;
  logic                 wr_en;
  logic                 empty_run;
  logic                 upd_fire;
  logic                 run_end;
  logic                 r_last;
  logic                 g_last;
  logic                 step_last;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        dist_q;
  logic [LOAD_W-1:0]    load_q;
  logic [COEF_W-1:0]    coeff;
  logic [RIW-1:0]       best_r;
  logic [GIW-1:0]       best_g;
  logic [LOAD_W-1:0]    best_load;
  pick_ctl_t            pick_ctl;
  pick_stat_t           pick_stat;

  // sizes in use, clamped to the storage
  assign n_use = (int'(num_robots) > MAX_ROBOTS) ? RCW'(MAX_ROBOTS) : RCW'(num_robots);
  assign m_use = (int'(num_goals) > MAX_GOALS) ? GCW'(MAX_GOALS) : GCW'(num_goals);

  // command decode
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign wr_en     = cmd_fire && (cmd.op == OP_WRITE)
                     && (int'(cmd.robot_index) < MAX_ROBOTS)
                     && (int'(cmd.goal_index) < MAX_GOALS);
  assign empty_run = cmd_fire && (cmd.op == OP_RUN)
                     && ((n_use == '0) || (m_use == '0));

  // scan position and step bookkeeping
  assign r_last    = (RCW'(r_cnt) + RCW'(1)) == n_use;
  assign g_last    = (GCW'(g_cnt) + GCW'(1)) == m_use;
  assign step_last = (GCW'(step_cnt) + GCW'(1)) == m_use;
  assign upd_fire  = (state == ST_UPDATE) && (!res.valid || res.ready);
  assign run_end   = empty_run || (upd_fire && step_last);

  assign wr_addr = AW'(int'(cmd.robot_index) * MAX_GOALS + int'(cmd.goal_index));
  assign rd_addr = AW'(int'(r_cnt) * MAX_GOALS + int'(g_cnt));
  assign coeff   = COEF_W'(largest) + COEF_W'(1);

  assign pick_ctl.cand  = (state == ST_SCAN) && !taken[g_cnt];
  assign pick_ctl.clear = (state == ST_IDLE) || upd_fire;

  // distance matrix
  glba_dist_mem #(
    .DEPTH     (DEPTH),
    .AW        (AW),
    .EW        (EW),
    .DIST_BITS (DIST_BITS),
    .RCW       (RCW),
    .GCW       (GCW)
  ) u_dist (
    .clk       (clk),
    .we        (wr_en),
    .waddr     (wr_addr),
    .distance  (cmd.distance),
    .reachable (cmd.reachable),
    .n_use     (n_use),
    .m_use     (m_use),
    .raddr     (rd_addr),
    .rdata     (dist_q)
  );

  // robot loads
  glba_load_mem #(
    .MAX_ROBOTS (MAX_ROBOTS),
    .RIW        (RIW)
  ) u_load (
    .clk   (clk),
    .rst   (rst),
    .clear (run_end),
    .we    (upd_fire),
    .waddr (best_r),
    .wdata (best_load + LOAD_W'(1)),
    .raddr (r_cnt),
    .rdata (load_q)
  );

  // cost pipeline and best pick
  glba_pick #(
    .RIW    (RIW),
    .GIW    (GIW),
    .EW     (EW),
    .COEF_W (COEF_W)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pick_ctl),
    .r_in      (r_cnt),
    .g_in      (g_cnt),
    .dist_q    (dist_q),
    .load_q    (load_q),
    .coeff     (coeff),
    .best_r    (best_r),
    .best_g    (best_g),
    .best_load (best_load),
    .stat      (pick_stat)
  );

  // sequencer, configuration and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      num_robots <= '0;
      num_goals  <= '0;
      largest    <= '0;
      taken      <= '0;
      r_cnt      <= '0;
      g_cnt      <= '0;
      step_cnt   <= '0;
      res.valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROBOTS: num_robots <= cfg_data[NROB_W-1:0];
          REG_NUM_GOALS:  num_goals  <= cfg_data[NGOAL_W-1:0];
          default: ;
        endcase
      end
      // result valid: set by an update, dropped once taken
      if (upd_fire) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (wr_en && cmd.reachable && (cmd.distance > largest)) begin
            largest <= cmd.distance;
          end
          if (empty_run) begin
            taken   <= '0;
            largest <= '0;
          end else if (cmd_fire && (cmd.op == OP_RUN)) begin
            r_cnt    <= '0;
            g_cnt    <= '0;
            step_cnt <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (r_last) begin
            r_cnt <= '0;
            if (g_last) begin
              state <= ST_DRAIN;
            end else begin
              g_cnt <= g_cnt + GIW'(1);
            end
          end else begin
            r_cnt <= r_cnt + RIW'(1);
          end
        end
        ST_DRAIN: begin
          if (!pick_stat.busy) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (upd_fire) begin
            if (step_last) begin
              taken   <= '0;
              largest <= '0;
              state   <= ST_IDLE;
            end else begin
              taken[best_g] <= 1'b1;
              step_cnt      <= step_cnt + GIW'(1);
              r_cnt         <= '0;
              g_cnt         <= '0;
              state         <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      res.robot_out <= ROBOT_W'(best_r);
      res.goal_out  <= GOAL_W'(best_g);
      res.last      <= step_last;
    end
  end

  // checks
  `GLBA_ASSERT_NOW(a_update_has_free_pick, clk, rst, state == ST_UPDATE, pick_stat.found && !taken[best_g], "update without a pick on a free goal")
  `GLBA_ASSERT_NOW(a_idle_pipe_empty, clk, rst, state == ST_IDLE, !pick_stat.busy, "cost pipeline busy while idle")
  `GLBA_ASSERT_NEXT(a_run_end_clears, clk, rst, upd_fire && step_last, state == ST_IDLE && taken == '0 && largest == '0, "run state not cleared after last result")

endmodule

// File: rtl/glba_dist_mem.sv
// ----------------------------------------------------------------------------
// glba_dist_mem
// Robot-by-goal distance matrix: one write port that encodes unreachable
// entries, one read port with a registered output.
// ----------------------------------------------------------------------------
module glba_dist_mem
  import glba_pkg::*;
#(
  parameter int DEPTH     = MAX_ROBOTS_DEF * MAX_GOALS_DEF,
  parameter int AW        = idx_bits(DEPTH),
  parameter int EW        = entry_bits(MAX_ROBOTS_DEF, MAX_GOALS_DEF, DIST_BITS_DEF),
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int RCW       = cnt_bits(MAX_ROBOTS_DEF),
  parameter int GCW       = cnt_bits(MAX_GOALS_DEF)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [DIST_BITS-1:0] distance,
  input  logic                 reachable,
  input  logic [RCW-1:0]       n_use,
  input  logic [GCW-1:0]       m_use,
  input  logic [AW-1:0]        raddr,
  output logic [EW-1:0]        rdata
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] wdata;

  // unreachable code follows the sizes in force at write time
  assign wdata = reachable ? EW'(distance)
                           : EW'(int'(n_use) * int'(m_use) + 1);

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/glba_load_mem.sv
// ----------------------------------------------------------------------------
// glba_load_mem
// Per-robot load counts: memory with registered read and per-entry valid
// bits, so that a whole run's loads clear together.
// ----------------------------------------------------------------------------
module glba_load_mem
  import glba_pkg::*;
#(
  parameter int MAX_ROBOTS = MAX_ROBOTS_DEF,
  parameter int RIW        = idx_bits(MAX_ROBOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              we,
  input  logic [RIW-1:0]    waddr,
  input  logic [LOAD_W-1:0] wdata,
  input  logic [RIW-1:0]    raddr,
  output logic [LOAD_W-1:0] rdata
);

  logic [LOAD_W-1:0]     mem [MAX_ROBOTS];
  logic [MAX_ROBOTS-1:0] vld;
  logic [LOAD_W-1:0]     rd_q;
  logic                  rd_vld;

  // data array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q   <= mem[raddr];
    rd_vld <= vld[raddr];
  end

  // valid bits, cleared at reset and at the end of each run
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // an entry never written since the last clear reads as zero
  assign rdata = rd_vld ? rd_q : '0;

endmodule

// File: rtl/glba_pick.sv
// ----------------------------------------------------------------------------
// glba_pick
// Cost pipeline: multiplies load by the load weight, adds the distance and
// keeps the first least-cost candidate of a step.
// ----------------------------------------------------------------------------
module glba_pick
  import glba_pkg::*;
#(
  parameter int RIW    = idx_bits(MAX_ROBOTS_DEF),
  parameter int GIW    = idx_bits(MAX_GOALS_DEF),
  parameter int EW     = entry_bits(MAX_ROBOTS_DEF, MAX_GOALS_DEF, DIST_BITS_DEF),
  parameter int COEF_W = DIST_BITS_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  pick_ctl_t         ctl,
  input  logic [RIW-1:0]    r_in,
  input  logic [GIW-1:0]    g_in,
  input  logic [EW-1:0]     dist_q,
  input  logic [LOAD_W-1:0] load_q,
  input  logic [COEF_W-1:0] coeff,
  output logic [RIW-1:0]    best_r,
  output logic [GIW-1:0]    best_g,
  output logic [LOAD_W-1:0] best_load,
  output pick_stat_t        stat
);

  localparam int PROD_W = COEF_W + LOAD_W;
  localparam int COST_W = ((EW > PROD_W) ? EW : PROD_W) + 1;

  logic              s1_v;
  logic [RIW-1:0]    s1_r;
  logic [GIW-1:0]    s1_g;
  logic              s2_v;
  logic [RIW-1:0]    s2_r;
  logic [GIW-1:0]    s2_g;
  logic [EW-1:0]     s2_dist;
  logic [PROD_W-1:0] s2_prod;
  logic [LOAD_W-1:0] s2_load;
  logic              found;
  logic [COST_W-1:0] best_cost;
  logic [COST_W-1:0] cost;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= ctl.cand;
      s2_v <= s1_v;
    end
  end

  // tags line up with the memory read data; then the load product
  always_ff @(posedge clk) begin
    s1_r    <= r_in;
    s1_g    <= g_in;
    s2_r    <= s1_r;
    s2_g    <= s1_g;
    s2_dist <= dist_q;
    s2_load <= load_q;
    s2_prod <= PROD_W'(coeff) * PROD_W'(load_q);
  end

  assign cost = COST_W'(s2_dist) + COST_W'(s2_prod);

  // strict compare keeps the first of equal candidates
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (s2_v && (!found || cost < best_cost)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && (!found || cost < best_cost)) begin
      best_cost <= cost;
      best_r    <= s2_r;
      best_g    <= s2_g;
      best_load <= s2_load;
    end
  end

  assign stat.found = found;
  assign stat.busy  = s1_v | s2_v;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: greedy load-balanced assignment core testbench
// Loads distance matrices over the command channel and issues runs under
// several robot/goal sizes. A behavioural auction predicts every (robot, goal)
// pair, and the result channel is checked pair by pair in order. Both channels
// idle at random, and the result side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb;
  import glba_pkg::*;

  localparam int ROWS      = MAX_ROBOTS_DEF;
  localparam int COLS      = MAX_GOALS_DEF;
  localparam int DW        = DIST_BITS_DEF;
  localparam int SETTLE    = 20;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic               op;
    logic [ROBOT_W-1:0] robot;
    logic [GOAL_W-1:0]  goal;
    logic [DW-1:0]      dval;
    logic               reach;
  } cmd_item_t;

  typedef struct packed {
    logic [ROBOT_W-1:0] robot;
    logic [GOAL_W-1:0]  goal;
    logic               last;
  } pair_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  glba_cmd_if #(.DIST_BITS(DW)) cmd_ch ();
  glba_res_if                   res_ch ();

  greedy_load_balanced_assignment_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // stimulus and expectations
  cmd_item_t   cmd_backlog[$];
  pair_t       pairs_due[$];

  // auction state mirrored from the block
  int unsigned       dist_mem [ROWS][COLS];
  logic [LOAD_W-1:0] load_cnt [ROWS];
  logic [COLS-1:0]   goal_mark;
  logic [DW-1:0]     max_finite;
  int unsigned       rob_cfg;
  int unsigned       goal_cfg;
  bit                entry_known [ROWS][COLS];

  int   errors;
  logic cmd_took;
  logic res_took;
  int   send_wait;
  bit   send_idles;
  int   recv_wait;
  bit   recv_idles;
  int   hold_requests;
  int   holds_served;
  int   hold_left;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned rows_used();
    return (rob_cfg > ROWS) ? ROWS : rob_cfg;
  endfunction

  function automatic int unsigned cols_used();
    return (goal_cfg > COLS) ? COLS : goal_cfg;
  endfunction

  // matrix write: finite distance or the unreachable code for current sizes
  function automatic void take_entry(input int r, input int g, input logic [DW-1:0] d,
                                     input logic reach);
    if (reach) begin
      dist_mem[r][g] = d;
      if (d > max_finite) max_finite = d;
    end else begin
      dist_mem[r][g] = rows_used() * cols_used() + 1;
    end
  endfunction

  // one greedy step per goal, cheapest (goal, robot) first, first wins on ties
  function automatic void play_auction();
    int unsigned n;
    int unsigned m;
    int unsigned step;
    int unsigned g;
    int unsigned r;
    int unsigned br;
    int unsigned bg;
    longint unsigned cost;
    longint unsigned best;
    longint unsigned coeff;
    bit found;
    pair_t p;
    n = rows_used();
    m = cols_used();
    coeff = longint'(max_finite) + 1;
    if (n > 0 && m > 0) begin
      for (step = 0; step < m; step++) begin
        found = 1'b0;
        best  = 0;
        br    = 0;
        bg    = 0;
        for (g = 0; g < m; g++) begin
          if (!goal_mark[g]) begin
            for (r = 0; r < n; r++) begin
              cost = longint'(dist_mem[r][g]) + coeff * longint'(load_cnt[r]);
              if (!found || cost < best) begin
                found = 1'b1;
                best  = cost;
                br    = r;
                bg    = g;
              end
            end
          end
        end
        goal_mark[bg] = 1'b1;
        load_cnt[br]  = load_cnt[br] + 1'b1;
        p.robot = br[ROBOT_W-1:0];
        p.goal  = bg[GOAL_W-1:0];
        p.last  = (step + 1 == m);
        pairs_due.insert(pairs_due.size(), p);
      end
    end
    foreach (load_cnt[i]) load_cnt[i] = '0;
    goal_mark  = '0;
    max_finite = '0;
  endfunction

  // prediction and result checks at the rising edge
  always @(posedge clk) begin : check_p
    pair_t want;
    if (rst) begin
      cmd_took <= 1'b0;
      res_took <= 1'b0;
    end else begin
      cmd_took <= cmd_ch.valid && cmd_ch.ready;
      res_took <= res_ch.valid && res_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (cmd_ch.op == OP_RUN) play_auction();
        else take_entry(cmd_ch.robot_index, cmd_ch.goal_index, cmd_ch.distance,
                        cmd_ch.reachable);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pairs_due.size() == 0) begin
          $error("result with no assignment due: robot_out %0d goal_out %0d",
                 res_ch.robot_out, res_ch.goal_out);
          errors++;
        end else begin
          want = pairs_due.pop_front();
          if (res_ch.robot_out !== want.robot) begin
            $error("robot_out mismatch: expected %0d, got %0d", want.robot, res_ch.robot_out);
            errors++;
          end
          if (res_ch.goal_out !== want.goal) begin
            $error("goal_out mismatch: expected %0d, got %0d", want.goal, res_ch.goal_out);
            errors++;
          end
          if (res_ch.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, res_ch.last);
            errors++;
          end
        end
      end
    end
  end

  // command driver, one item at a time from the backlog
  always @(negedge clk) begin : drive_p
    cmd_item_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_wait = 0;
    end else if (!cmd_ch.valid || cmd_took) begin
      if (send_wait > 0) begin
        send_wait--;
        cmd_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        cmd_ch.op          <= nxt.op;
        cmd_ch.robot_index <= nxt.robot;
        cmd_ch.goal_index  <= nxt.goal;
        cmd_ch.distance    <= nxt.dval;
        cmd_ch.reachable   <= nxt.reach;
        cmd_ch.valid       <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_idles = !send_idles;
        send_wait = send_idles ? $urandom_range(0, 5) : 0;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random gaps, plus a long hold-off on request
  always @(negedge clk) begin : sink_p
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (res_took) begin
        if ($urandom_range(0, 31) == 0) recv_idles = !recv_idles;
        recv_wait = recv_idles ? $urandom_range(0, 5) : 0;
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // mostly small values for ties and load effects, some wide and extreme
  function automatic logic [DW-1:0] pick_distance();
    case ($urandom_range(0, 3))
      0:       return DW'($urandom_range(0, 7));
      1:       return DW'($urandom_range(0, 300));
      2:       return $urandom_range(0, 1) ? {DW{1'b1}} : '0;
      default: return DW'($urandom_range(0, (1 << DW) - 1));
    endcase
  endfunction

  function automatic void push_write(input int r, input int g, input logic [DW-1:0] d,
                                     input logic reach);
    cmd_item_t it;
    it.op    = OP_WRITE;
    it.robot = r[ROBOT_W-1:0];
    it.goal  = g[GOAL_W-1:0];
    it.dval  = d;
    it.reach = reach;
    cmd_backlog.insert(cmd_backlog.size(), it);
    entry_known[r][g] = 1'b1;
  endfunction

  // run item, other fields carry noise
  function automatic void push_run();
    cmd_item_t it;
    it.op    = OP_RUN;
    it.robot = ROBOT_W'($urandom_range(0, ROWS - 1));
    it.goal  = GOAL_W'($urandom_range(0, COLS - 1));
    it.dval  = DW'($urandom_range(0, (1 << DW) - 1));
    it.reach = 1'($urandom_range(0, 1));
    cmd_backlog.insert(cmd_backlog.size(), it);
  endfunction

  // every entry a run will read must have been written
  function automatic void fill_matrix();
    for (int r = 0; r < rows_used(); r++)
      for (int g = 0; g < cols_used(); g++)
        if (!entry_known[r][g])
          push_write(r, g, pick_distance(), $urandom_range(0, 4) != 0);
  endfunction

  // wait until every item is taken and every pair has come out
  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || pairs_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_NUM_ROBOTS) rob_cfg = val & 5'h1f;
    else goal_cfg = val & 6'h3f;
  endtask

  task automatic set_sizes(input int unsigned nr, input int unsigned ng);
    drain();
    write_reg(REG_NUM_ROBOTS, nr);
    write_reg(REG_NUM_GOALS, ng);
  endtask

  // random writes and runs over one setting, always ending in a run
  task automatic random_phase(input int unsigned nr, input int unsigned ng);
    int k;
    set_sizes(nr, ng);
    fill_matrix();
    k = $urandom_range(6, 12);
    repeat (k) begin
      if ($urandom_range(0, 4) == 0) begin
        push_run();
      end else if (rows_used() > 0 && cols_used() > 0 && $urandom_range(0, 3) != 0) begin
        push_write($urandom_range(0, rows_used() - 1), $urandom_range(0, cols_used() - 1),
                   pick_distance(), $urandom_range(0, 4) != 0);
      end else begin
        push_write($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                   pick_distance(), $urandom_range(0, 4) != 0);
      end
    end
    push_run();
  endtask

  // main sequence
  initial begin
    int unsigned nr;
    int unsigned ng;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.op          = OP_WRITE;
    cmd_ch.robot_index = '0;
    cmd_ch.goal_index  = '0;
    cmd_ch.distance    = '0;
    cmd_ch.reachable   = 1'b0;
    res_ch.ready       = 1'b0;
    errors             = 0;
    send_idles         = 1'b1;
    recv_idles         = 1'b1;
    hold_requests      = 0;
    holds_served       = 0;
    rob_cfg            = 0;
    goal_cfg           = 0;
    goal_mark          = '0;
    max_finite         = '0;
    foreach (load_cnt[i]) load_cnt[i] = '0;
    foreach (dist_mem[r, g]) begin
      dist_mem[r][g]    = 0;
      entry_known[r][g] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes of distance, unreachable code, overwritten maximum
    set_sizes(2, 3);
    push_write(0, 0, {DW{1'b1}}, 1'b1);
    push_write(0, 0, 3, 1'b1);
    push_write(0, 1, 0, 1'b1);
    push_write(0, 2, 0, 1'b0);
    push_write(1, 0, 4, 1'b1);
    push_write(1, 1, 9, 1'b1);
    push_write(1, 2, 2, 1'b1);
    push_run();
    // same matrix again with the maximum cleared
    push_run();

    // all costs equal: ties resolved by scan order
    set_sizes(3, 3);
    for (int r = 0; r < 3; r++)
      for (int g = 0; g < 3; g++)
        push_write(r, g, 5, 1'b1);
    push_run();

    // empty runs
    set_sizes(0, 5);
    push_run();
    set_sizes(3, 0);
    push_run();

    // receiver holds off while further items wait behind a run
    set_sizes(4, 4);
    fill_matrix();
    hold_requests++;
    push_run();
    for (int i = 0; i < 6; i++)
      push_write($urandom_range(0, 3), $urandom_range(0, 3), pick_distance(), 1'b1);
    push_run();

    // oversized registers: unreachable code from the clamped sizes
    set_sizes(31, 63);
    push_write(0, 0, 0, 1'b0);
    push_write(15, 31, {DW{1'b1}}, 1'b1);
    for (int i = 0; i < 4; i++)
      push_write($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                 pick_distance(), 1'($urandom_range(0, 1)));
    set_sizes(2, 2);
    push_run();

    // random phases, mostly small sizes
    repeat (10) begin
      if ($urandom_range(0, 3) == 0) begin
        nr = $urandom_range(6, 16);
        ng = $urandom_range(0, 4);
      end else begin
        nr = $urandom_range(0, 5);
        ng = $urandom_range(0, 6);
      end
      random_phase(nr, ng);
    end

    drain();
    if (errors == 0 && pairs_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/glba_pkg.sv
rtl/glba_ifs.sv
rtl/glba_dist_mem.sv
rtl/glba_load_mem.sv
rtl/glba_pick.sv
rtl/greedy_load_balanced_assignment_core.sv
sim/tb.sv
